### rtl/adpe_pkg.sv
// Shared types and codes for the data-processing execute block.
// Opcode, condition and shift-kind encodings plus the NZCV flag layout.
// No dependencies.
`timescale 1ns / 1ps

package adpe_pkg;

    typedef logic [3:0] t_opcode;
    typedef logic [3:0] t_cond;
    typedef logic [1:0] t_shift_kind;
    typedef logic [3:0] t_flags;

    localparam t_opcode OP_AND = 4'h0;
    localparam t_opcode OP_EOR = 4'h1;
    localparam t_opcode OP_SUB = 4'h2;
    localparam t_opcode OP_RSB = 4'h3;
    localparam t_opcode OP_ADD = 4'h4;
    localparam t_opcode OP_TST = 4'h8;
    localparam t_opcode OP_TEQ = 4'h9;
    localparam t_opcode OP_CMP = 4'hA;
    localparam t_opcode OP_ORR = 4'hC;
    localparam t_opcode OP_MOV = 4'hD;

    localparam t_cond COND_EQ = 4'h0;
    localparam t_cond COND_NE = 4'h1;
    localparam t_cond COND_CS = 4'h2;
    localparam t_cond COND_CC = 4'h3;
    localparam t_cond COND_MI = 4'h4;
    localparam t_cond COND_PL = 4'h5;
    localparam t_cond COND_VS = 4'h6;
    localparam t_cond COND_VC = 4'h7;
    localparam t_cond COND_HI = 4'h8;
    localparam t_cond COND_LS = 4'h9;
    localparam t_cond COND_GE = 4'hA;
    localparam t_cond COND_LT = 4'hB;
    localparam t_cond COND_GT = 4'hC;
    localparam t_cond COND_LE = 4'hD;
    localparam t_cond COND_AL = 4'hE;

    localparam t_shift_kind SH_LSL = 2'd0;
    localparam t_shift_kind SH_LSR = 2'd1;
    localparam t_shift_kind SH_ASR = 2'd2;
    localparam t_shift_kind SH_ROR = 2'd3;

    localparam int FLAG_N_BIT = 3;
    localparam int FLAG_Z_BIT = 2;
    localparam int FLAG_C_BIT = 1;
    localparam int FLAG_V_BIT = 0;

    localparam logic [7:0] SHIFT_FULL = 8'd32;

    function automatic logic cond_pass(input t_cond cond, input t_flags f);
        logic n, z, c, v;
        n = f[FLAG_N_BIT];
        z = f[FLAG_Z_BIT];
        c = f[FLAG_C_BIT];
        v = f[FLAG_V_BIT];
        unique case (cond)
            COND_EQ: cond_pass = z;
            COND_NE: cond_pass = !z;
            COND_CS: cond_pass = c;
            COND_CC: cond_pass = !c;
            COND_MI: cond_pass = n;
            COND_PL: cond_pass = !n;
            COND_VS: cond_pass = v;
            COND_VC: cond_pass = !v;
            COND_HI: cond_pass = c && !z;
            COND_LS: cond_pass = !c || z;
            COND_GE: cond_pass = (n == v);
            COND_LT: cond_pass = (n != v);
            COND_GT: cond_pass = !z && (n == v);
            COND_LE: cond_pass = z || (n != v);
            COND_AL: cond_pass = 1'b1;
            default: cond_pass = 1'b0;
        endcase
    endfunction

endpackage

### rtl/arm_data_processing_execute.sv
// Top level of the data-processing execute block: register file, shifter, ALU, flags.
// Depends on adpe_pkg for opcode, condition and shift encodings.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_valid / o_stall carry one instruction word on i_instr_word.
//   Output channel: o_valid / i_stall carry one result word per instruction
//   (executed, reg_written, dest_index, alu_result, flags_after, bad_opcode).
//   An accepted word passes through the execute stage register and then the
//   output register. Throughput: one word per cycle while the receiver does
//   not stall, set by the single execute stage that reads the register file
//   memories, computes and writes back; a result read right after a write
//   to the same register is forwarded from the write-back register.
//   The register file lives in two synchronous memories with registered read
//   (Rn/Rm ports and an Rs copy); per-register valid bits make unwritten
//   entries read as zero.
//   Reset (i_rst_n low, synchronous) clears the flags, the valid bits and the
//   pipeline; the block accepts words as soon as reset is released.
//   When the receiver stalls, the result word holds; the execute stage keeps
//   its instruction and o_stall rises once both stages are full.
module arm_data_processing_execute
    import adpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_executed,
    output logic        o_reg_written,
    output logic [3:0]  o_dest_index,
    output logic [31:0] o_alu_result,
    output logic [3:0]  o_flags_after,
    output logic        o_bad_opcode
);

    logic [31:0] mem_a [16];
    logic [31:0] mem_b [16];
    logic [15:0] r_reg_vld;

    logic        r_s1_valid;
    logic [31:0] r_s1_instr;
    logic [31:0] r_rn_q, r_rm_q, r_rs_q;
    logic        r_rn_vld, r_rm_vld, r_rs_vld;
    logic        r_rn_fwd, r_rm_fwd, r_rs_fwd;
    logic [31:0] r_wb_data;
    t_flags      r_flags;
    logic        r_out_valid;

    logic        in_accept, retire;
    logic [3:0]  in_rn, in_rm, in_rs;

    logic        wr_en;
    logic [31:0] res;
    t_flags      n_flags;
    logic        pass, supported, writes;

    logic [31:0] rn_val, rm_val, rs_val;

    assign in_rn     = i_instr_word[19:16];
    assign in_rm     = i_instr_word[3:0];
    assign in_rs     = i_instr_word[11:8];
    assign retire    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !retire;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;

    // memories: synchronous read on accept, write back at retire
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rn_q <= mem_a[in_rn];
            r_rm_q <= mem_a[in_rm];
            r_rs_q <= mem_b[in_rs];
        end
        if (wr_en) begin
            mem_a[r_s1_instr[15:12]] <= res;
            mem_b[r_s1_instr[15:12]] <= res;
        end
    end

    // read data is stale for a register written at the same edge
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rn_vld <= r_reg_vld[in_rn];
            r_rm_vld <= r_reg_vld[in_rm];
            r_rs_vld <= r_reg_vld[in_rs];
            r_rn_fwd <= wr_en && (r_s1_instr[15:12] == in_rn);
            r_rm_fwd <= wr_en && (r_s1_instr[15:12] == in_rm);
            r_rs_fwd <= wr_en && (r_s1_instr[15:12] == in_rs);
            r_s1_instr <= i_instr_word;
        end
        if (wr_en) begin
            r_wb_data <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_reg_vld   <= '0;
            r_flags     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (retire) begin
                r_s1_valid <= 1'b0;
            end
            if (retire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_reg_vld[r_s1_instr[15:12]] <= 1'b1;
            end
        end
    end

    assign rn_val = r_rn_fwd ? r_wb_data : (r_rn_vld ? r_rn_q : 32'd0);
    assign rm_val = r_rm_fwd ? r_wb_data : (r_rm_vld ? r_rm_q : 32'd0);
    assign rs_val = r_rs_fwd ? r_wb_data : (r_rs_vld ? r_rs_q : 32'd0);

    // operand2 and shifter carry
    logic        cin, sc;
    logic [31:0] op2;
    logic [63:0] imm_rot, ror_w;
    logic [7:0]  sh_amt;
    logic [32:0] lsl_t, lsr_t, asr_t;
    logic        sh_big, rrx;
    t_shift_kind kind;

    always_comb begin
        cin     = r_flags[FLAG_C_BIT];
        kind    = r_s1_instr[6:5];
        imm_rot = {32'd0, 24'd0, r_s1_instr[7:0]};
        imm_rot = {imm_rot[31:0], imm_rot[31:0]} >> {r_s1_instr[11:8], 1'b0};
        rrx     = 1'b0;
        if (r_s1_instr[4]) begin
            sh_amt = rs_val[7:0];
        end else begin
            sh_amt = {3'd0, r_s1_instr[11:7]};
            if (r_s1_instr[11:7] == 5'd0) begin
                if (kind == SH_LSR || kind == SH_ASR) begin
                    sh_amt = SHIFT_FULL;
                end
                rrx = (kind == SH_ROR);
            end
        end
        sh_big = |sh_amt[7:5];
        lsl_t  = {1'b0, rm_val} << sh_amt[4:0];
        lsr_t  = {rm_val, 1'b0} >> sh_amt[4:0];
        asr_t  = 33'($signed({rm_val, 1'b0}) >>> sh_amt[4:0]);
        ror_w  = {rm_val, rm_val} >> sh_amt[4:0];

        op2 = rm_val;
        sc  = cin;
        if (r_s1_instr[25]) begin
            op2 = imm_rot[31:0];
            sc  = (r_s1_instr[11:8] == 4'd0) ? cin : imm_rot[31];
        end else if (rrx) begin
            op2 = {cin, rm_val[31:1]};
            sc  = rm_val[0];
        end else if (sh_amt != 8'd0) begin
            case (kind)
                SH_LSL: begin
                    if (!sh_big) begin
                        op2 = lsl_t[31:0];
                        sc  = lsl_t[32];
                    end else begin
                        op2 = 32'd0;
                        sc  = (sh_amt == SHIFT_FULL) ? rm_val[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (!sh_big) begin
                        op2 = lsr_t[32:1];
                        sc  = lsr_t[0];
                    end else begin
                        op2 = 32'd0;
                        sc  = (sh_amt == SHIFT_FULL) ? rm_val[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (!sh_big) begin
                        op2 = asr_t[32:1];
                        sc  = asr_t[0];
                    end else begin
                        op2 = {32{rm_val[31]}};
                        sc  = rm_val[31];
                    end
                end
                default: begin
                    op2 = ror_w[31:0];
                    sc  = ror_w[31];
                end
            endcase
        end
    end

    // ALU, flags and write-back decode
    logic [32:0] sum, dif, rdif;
    logic        c;

    always_comb begin
        sum       = {1'b0, rn_val} + {1'b0, op2};
        dif       = {1'b0, rn_val} - {1'b0, op2};
        rdif      = {1'b0, op2} - {1'b0, rn_val};
        pass      = cond_pass(r_s1_instr[31:28], r_flags);
        supported = 1'b1;
        writes    = 1'b1;
        c         = sc;
        res       = 32'd0;
        unique case (r_s1_instr[24:21])
            OP_AND, OP_TST: res = rn_val & op2;
            OP_EOR, OP_TEQ: res = rn_val ^ op2;
            OP_SUB, OP_CMP: begin
                res = dif[31:0];
                c   = !dif[32];
            end
            OP_RSB: begin
                res = rdif[31:0];
                c   = !rdif[32];
            end
            OP_ADD: begin
                res = sum[31:0];
                c   = sum[32];
            end
            OP_ORR: res = rn_val | op2;
            OP_MOV: res = op2;
            default: supported = 1'b0;
        endcase
        if (r_s1_instr[24:21] inside {OP_TST, OP_TEQ, OP_CMP}) begin
            writes = 1'b0;
        end
        n_flags = r_flags;
        if (pass && supported && r_s1_instr[20]) begin
            n_flags[FLAG_N_BIT] = res[31];
            n_flags[FLAG_Z_BIT] = (res == 32'd0);
            n_flags[FLAG_C_BIT] = c;
        end
    end

    assign wr_en = retire && pass && supported && writes;

    always_ff @(posedge i_clk) begin
        if (retire) begin
            o_executed    <= pass && supported;
            o_reg_written <= pass && supported && writes;
            o_dest_index  <= (pass && supported && writes) ? r_s1_instr[15:12] : 4'd0;
            o_alu_result  <= (pass && supported) ? res : 32'd0;
            o_flags_after <= n_flags;
            o_bad_opcode  <= pass && !supported;
        end
    end

    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("stall raised with an empty execute stage");

    a_retire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        retire |=> r_out_valid)
        else $error("retired word not presented");

    a_write_implies_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!o_reg_written || o_executed) && !(o_bad_opcode && o_executed))
        else $error("inconsistent result status");

    a_bad_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (retire && !supported) |=> (r_flags == $past(r_flags)))
        else $error("flags changed on an unsupported opcode");

    a_no_write_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> retire && pass)
        else $error("register write without a passing condition");

endmodule
